// ----- rtl/core/kpsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_pkg - keypad scan with debounce and timeout, shared definitions
// Phase encoding, field widths, key map and column search helper.
// ----------------------------------------------------------------------------
package kpsd_pkg;

  // width of the press wait counter and of the timeout limit
  localparam int unsigned TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] WAIT_MAX = {TIMEOUT_W{1'b1}};

  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
  localparam logic [2:0] ALL_COLS       = 3'b111;
  localparam logic [1:0] NO_COL         = 2'd3;
  localparam logic [6:0] NO_KEY         = 7'h54;  // ASCII 'T'

  // request kinds on the input channel
  localparam logic [1:0] KIND_TICK       = 2'd0;
  localparam logic [1:0] KIND_START_TO   = 2'd1;
  localparam logic [1:0] KIND_START_NOTO = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_WAIT_RELEASE = 3'd1,
    PH_RELEASE_DEB  = 3'd2,
    PH_WAIT_PRESS   = 3'd3,
    PH_PRESS_DEB    = 3'd4,
    PH_SCAN         = 3'd5
  } phase_t;

  // ascii key at a column and row of the 4x3 matrix
  function automatic logic [6:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
    logic [6:0] k;
    k = NO_KEY;
    unique case ({col, row})
      4'h0: k = 7'h31;  // '1'
      4'h1: k = 7'h34;  // '4'
      4'h2: k = 7'h37;  // '7'
      4'h3: k = 7'h2A;  // '*'
      4'h4: k = 7'h32;  // '2'
      4'h5: k = 7'h35;  // '5'
      4'h6: k = 7'h38;  // '8'
      4'h7: k = 7'h30;  // '0'
      4'h8: k = 7'h33;  // '3'
      4'h9: k = 7'h36;  // '6'
      4'hA: k = 7'h39;  // '9'
      4'hB: k = 7'h23;  // '#'
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  // lowest pressed (low) column at or after start, NO_COL when none
  function automatic logic [1:0] next_col(input logic [2:0] pressed, input logic [1:0] start);
    logic [1:0] res;
    logic       hit;
    res = NO_COL;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!hit && (2'(i) >= start) && !pressed[i]) begin
        res = 2'(i);
        hit = 1'b1;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/keypad_scan_debounce_timeout.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_scan_debounce_timeout - 4x3 matrix keypad scanner
// Debounced release/press detection, optional tick timeout and row scan.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid/in_ready) carries one transaction per keypad
//    tick or request: a column sample tick, a start with timeout, or a start
//    without timeout
//  - output channel (out_valid/out_ready) returns one status transaction for
//    every input transaction: row lines to drive, busy, done, key and timeout
//  - the status of a transaction is registered: it is in the output
//    register on the cycle after it is accepted
//  - throughput is one transaction per cycle when not stalled; the sequencer
//    state and output register update together in one pass of short logic
//  - when the receiver stalls the output register holds, and a new input
//    transaction is still taken on the cycle the held one is taken
//  - cfg_wr_en/cfg_wr_data write the debounce tick count; write only idle
//  - reset (rst_n low, synchronous) returns the scanner to idle, empties the
//    output register and sets the debounce count to 20
// ----------------------------------------------------------------------------
module keypad_scan_debounce_timeout (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_column_sense,
  input  wire logic [15:0] in_timeout_ticks,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_row_drive,
  output logic             out_busy_res,
  output logic             out_key_done,
  output logic [6:0]       out_key_char,
  output logic             out_timed_out
);
  import kpsd_pkg::*;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [TIMEOUT_W-1:0]   wait_cnt_r, wait_cnt_nxt;
  logic [TIMEOUT_W-1:0]   limit_r, limit_nxt;
  logic                   no_to_r, no_to_nxt;
  logic [7:0]             deb_cnt_r, deb_cnt_nxt;
  logic [2:0]             pressed_r, pressed_nxt;
  logic [3:0]             scan_pos_r, scan_pos_nxt;
  logic [6:0]             found_r, found_nxt;
  logic [7:0]             deb_ticks_r;

  // output register
  logic                   out_valid_r;
  logic [3:0]             row_drive_r, row_drive_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r;
  logic [6:0]             key_r, key_nxt;
  logic                   tout_r, tout_nxt;

  logic                   accept;
  logic                   done;
  logic [TIMEOUT_W-1:0]   wait_inc;
  logic                   limit_now;
  logic                   limit_inc;
  logic [1:0]             scan_col;
  logic [1:0]             scan_row;
  logic [3:0]             cols_ext;
  logic [1:0]             adv_col;
  logic                   adv;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // limit checks before and after this tick's count
  assign wait_inc  = (!no_to_r && (wait_cnt_r != WAIT_MAX)) ? wait_cnt_r + 1'b1 : wait_cnt_r;
  assign limit_now = !no_to_r && (wait_cnt_r >= limit_r);
  assign limit_inc = !no_to_r && (wait_inc >= limit_r);

  assign scan_col = scan_pos_r[3:2];
  assign scan_row = scan_pos_r[1:0];
  assign cols_ext = {1'b1, in_column_sense};
  assign adv_col  = next_col(pressed_r, scan_col + 2'd1);

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    wait_cnt_nxt = wait_cnt_r;
    limit_nxt    = limit_r;
    no_to_nxt    = no_to_r;
    deb_cnt_nxt  = deb_cnt_r;
    pressed_nxt  = pressed_r;
    scan_pos_nxt = scan_pos_r;
    found_nxt    = found_r;
    done         = 1'b0;
    adv          = 1'b0;
    if (((in_kind == KIND_START_TO) || (in_kind == KIND_START_NOTO)) && (phase_r == PH_IDLE)) begin
      no_to_nxt    = (in_kind == KIND_START_NOTO);
      limit_nxt    = (in_kind == KIND_START_NOTO) ? '0 : TIMEOUT_W'(in_timeout_ticks);
      wait_cnt_nxt = '0;
      deb_cnt_nxt  = '0;
      pressed_nxt  = ALL_COLS;
      scan_pos_nxt = '0;
      found_nxt    = NO_KEY;
      phase_nxt    = PH_WAIT_RELEASE;
    end else if (in_kind == KIND_TICK) begin
      unique case (phase_r)
        PH_WAIT_RELEASE: begin
          if (in_column_sense == ALL_COLS) begin
            deb_cnt_nxt = deb_ticks_r;
            phase_nxt   = PH_RELEASE_DEB;
          end
        end
        PH_RELEASE_DEB: begin
          priority if (deb_cnt_r != 8'd0) begin
            deb_cnt_nxt = deb_cnt_r - 8'd1;
          end else if (in_column_sense == ALL_COLS) begin
            wait_cnt_nxt = '0;
            phase_nxt    = PH_WAIT_PRESS;
          end else begin
            phase_nxt = PH_WAIT_RELEASE;
          end
        end
        PH_WAIT_PRESS: begin
          if (limit_now) begin
            deb_cnt_nxt = deb_ticks_r;
            phase_nxt   = PH_PRESS_DEB;
          end else begin
            wait_cnt_nxt = wait_inc;
            if ((in_column_sense != ALL_COLS) || limit_inc) begin
              deb_cnt_nxt = deb_ticks_r;
              phase_nxt   = PH_PRESS_DEB;
            end
          end
        end
        PH_PRESS_DEB: begin
          priority if (deb_cnt_r != 8'd0) begin
            deb_cnt_nxt = deb_cnt_r - 8'd1;
          end else if (in_column_sense != ALL_COLS) begin
            pressed_nxt  = in_column_sense;
            scan_pos_nxt = {next_col(in_column_sense, 2'd0), 2'b00};
            phase_nxt    = PH_SCAN;
          end else if (limit_now) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_WAIT_PRESS;
          end
        end
        PH_SCAN: begin
          priority if (scan_col == NO_COL) begin
            done = 1'b1;
          end else if (!cols_ext[scan_col]) begin
            found_nxt = key_lookup(scan_col, scan_row);
            adv       = 1'b1;
          end else if (scan_row != 2'd3) begin
            scan_pos_nxt = scan_pos_r + 4'd1;
          end else begin
            adv = 1'b1;
          end
          if (adv) begin
            if (adv_col == NO_COL) begin
              done = 1'b1;
            end else begin
              scan_pos_nxt = {adv_col, 2'b00};
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    if (done) begin
      phase_nxt = PH_IDLE;
    end
  end

  // result fields
  always_comb begin
    row_drive_nxt = (phase_nxt == PH_SCAN) ? 4'(~(4'b0001 << scan_pos_nxt[1:0])) : 4'b0000;
    busy_nxt      = (phase_nxt != PH_IDLE);
    key_nxt       = done ? found_nxt : 7'd0;
    tout_nxt      = done && (found_nxt == NO_KEY);
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_cnt_r  <= '0;
      limit_r     <= '0;
      no_to_r     <= 1'b0;
      deb_cnt_r   <= '0;
      pressed_r   <= ALL_COLS;
      scan_pos_r  <= '0;
      found_r     <= NO_KEY;
      deb_ticks_r <= DEBOUNCE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        deb_ticks_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        wait_cnt_r <= wait_cnt_nxt;
        limit_r    <= limit_nxt;
        no_to_r    <= no_to_nxt;
        deb_cnt_r  <= deb_cnt_nxt;
        pressed_r  <= pressed_nxt;
        scan_pos_r <= scan_pos_nxt;
        found_r    <= found_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      row_drive_r <= row_drive_nxt;
      busy_r      <= busy_nxt;
      done_r      <= done;
      key_r       <= key_nxt;
      tout_r      <= tout_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_drive = row_drive_r;
  assign out_busy_res  = busy_r;
  assign out_key_done  = done_r;
  assign out_key_char  = key_r;
  assign out_timed_out = tout_r;

endmodule
`default_nettype wire

// ----- rtl/core/kpsd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_checker - port level checks for the keypad scanner
// Watches the result channel and the consistency of the status fields.
// ----------------------------------------------------------------------------
module kpsd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_row_drive,
  input wire logic       out_busy_res,
  input wire logic       out_key_done,
  input wire logic [6:0] out_key_char,
  input wire logic       out_timed_out
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_char) && $stable(out_row_drive))
    else $error("result changed while stalled");

  // finishing leaves the scanner idle with rows all low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_done |-> !out_busy_res && (out_row_drive == 4'b0000))
    else $error("done while still busy");

  // key and timeout only with done
  a_key_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_done |-> (out_key_char == 7'd0) && !out_timed_out)
    else $error("key reported without done");

  // timeout flag matches the no-key character
  a_timeout_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_done |-> (out_timed_out == (out_key_char == 7'h54)))
    else $error("timeout flag inconsistent with key");

  // during the row scan exactly one row is driven low
  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_drive != 4'b0000) |-> ($countones(out_row_drive) == 3) && out_busy_res)
    else $error("bad row drive pattern");

endmodule

bind keypad_scan_debounce_timeout kpsd_checker u_kpsd_checker (.*);
`default_nettype wire
